// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the word clock mask block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/wccm_pkg.sv =====
// ----------------------------------------------------------------------------
// Word clock mask package
// Field widths, word positions and the classified item shared by all parts.
// ----------------------------------------------------------------------------
package wccm_pkg;

  localparam int HOUR_W     = 5;
  localparam int MINUTE_W   = 6;
  localparam int ROW_IDX_W  = 4;
  localparam int ROW_BITS_W = 11;
  localparam int MAX_COLS   = 16;

  localparam int HOURS_PER_CYCLE = 12;
  localparam logic [MINUTE_W-1:0] MINUTE_MAX = 6'd59;
  // Multiplying by 13 and shifting by 6 divides a clamped minute by five.
  localparam logic [3:0] SLOT_RECIP = 4'd13;
  localparam int SLOT_SHIFT = 6;
  localparam logic [2:0] MINUTES_PER_SLOT = 3'd5;
  localparam logic [3:0] SLOT_HALF = 4'd5;
  localparam logic [3:0] HOUR_EIN = 4'd12;

  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [3:0] col;
    logic [3:0] row;
    logic [2:0] len;
  } clock_word_t;

  typedef struct packed {
    logic [3:0] slot;
    logic [2:0] extra;
    logic [3:0] hour_word;
    logic       full;
  } wccm_item_t;

  localparam clock_word_t W_ES      = '{4'd0,  4'd0, 3'd2};
  localparam clock_word_t W_IST     = '{4'd3,  4'd0, 3'd3};
  localparam clock_word_t W_FUENF   = '{4'd7,  4'd0, 3'd4};
  localparam clock_word_t W_ZEHN    = '{4'd0,  4'd1, 3'd4};
  localparam clock_word_t W_TWENTY  = '{4'd4,  4'd1, 3'd7};
  localparam clock_word_t W_QUARTER = '{4'd4,  4'd2, 3'd7};
  localparam clock_word_t W_VOR     = '{4'd0,  4'd3, 3'd3};
  localparam clock_word_t W_NACH    = '{4'd7,  4'd3, 3'd4};
  localparam clock_word_t W_HALB    = '{4'd0,  4'd4, 3'd4};
  localparam clock_word_t W_UHR     = '{4'd4,  4'd9, 3'd3};
  localparam clock_word_t W_DOT1    = '{4'd7,  4'd9, 3'd1};
  localparam clock_word_t W_DOT2    = '{4'd8,  4'd9, 3'd1};
  localparam clock_word_t W_DOT3    = '{4'd9,  4'd9, 3'd1};
  localparam clock_word_t W_DOT4    = '{4'd10, 4'd9, 3'd1};
  localparam clock_word_t W_EIN     = '{4'd0,  4'd9, 3'd3};

  localparam clock_word_t HOUR_POS [HOURS_PER_CYCLE] = '{
    '{4'd5, 4'd8, 3'd5}, '{4'd0, 4'd9, 3'd4}, '{4'd7, 4'd7, 3'd4},
    '{4'd0, 4'd5, 3'd4}, '{4'd7, 4'd5, 3'd4}, '{4'd7, 4'd4, 3'd4},
    '{4'd0, 4'd6, 3'd5}, '{4'd5, 4'd6, 3'd6}, '{4'd1, 4'd8, 3'd4},
    '{4'd3, 4'd7, 3'd4}, '{4'd0, 4'd7, 3'd4}, '{4'd5, 4'd4, 3'd3}
  };

  // Pixels that a word lights in the given row.
  function automatic logic [MAX_COLS-1:0] word_row_bits(clock_word_t w, logic [3:0] row);
    logic [MAX_COLS-1:0] ones;
    ones = (MAX_COLS'(1) << w.len) - MAX_COLS'(1);
    return (w.row == row) ? (ones << w.col) : '0;
  endfunction

endpackage

// ===== hdl/wccm_if.sv =====
// ----------------------------------------------------------------------------
// Word clock mask channels
// Valid/ready channels for time beats in and row beats out.
// ----------------------------------------------------------------------------
interface wccm_in_if import wccm_pkg::*;;
  logic                valid;
  logic                ready;
  logic [HOUR_W-1:0]   hour;
  logic [MINUTE_W-1:0] minute;

  modport source (output valid, hour, minute, input ready);
  modport sink   (input valid, hour, minute, output ready);
endinterface

interface wccm_out_if import wccm_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [ROW_IDX_W-1:0]  row_index;
  logic [ROW_BITS_W-1:0] new_row_bits;
  logic [ROW_BITS_W-1:0] old_row_bits;
  logic                  fade_needed;
  logic                  last_row;

  modport source (output valid, row_index, new_row_bits, old_row_bits, fade_needed,
                  last_row, input ready);
  modport sink   (input valid, row_index, new_row_bits, old_row_bits, fade_needed,
                  last_row, output ready);
endinterface

// ===== hdl/word_clock_time_to_pixel_mask.sv =====
// ----------------------------------------------------------------------------
// Word clock time to pixel mask
// Turns an hour and a minute into the row-by-row lit mask of a word clock.
// ----------------------------------------------------------------------------
// Usage:
//   in_i carries one time beat (hour, minute) per valid/ready handshake.
//   out_o carries ROWS row beats per time beat, rows in ascending order,
//   each with the new and the previous row bits, the fade flag and a
//   last-row marker on the final row.
//   The front end classifies a time beat in the cycle it is accepted and
//   queues it; the back end builds the whole mask in the cycle it takes an
//   item from the queue, and the first row beat is valid in the next cycle.
//   The back end sends one row beat per cycle while the receiver is
//   ready; the next mask loads in the cycle the last row beat is taken.
//   The two-entry queue keeps accepting time beats while rows are still
//   going out. After reset the stored mask is all zero and no fade is
//   reported for the first frame. When the receiver stalls, the current
//   row beat holds and the queue fills, after which in_i.ready drops.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module word_clock_time_to_pixel_mask import wccm_pkg::*; #(
  parameter int COLUMNS = 11,
  parameter int ROWS    = 10
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  wccm_in_if.sink    in_i,
  wccm_out_if.source out_o
);

  logic       push_valid, push_ready;
  wccm_item_t push_item;
  logic       pop_valid, pop_ready;
  wccm_item_t pop_item;

  wccm_front u_front (
    .in_i         (in_i),
    .push_valid_o (push_valid),
    .push_item_o  (push_item),
    .push_ready_i (push_ready)
  );

  wccm_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_item_i  (push_item),
    .push_ready_o (push_ready),
    .pop_valid_o  (pop_valid),
    .pop_item_o   (pop_item),
    .pop_ready_i  (pop_ready)
  );

  wccm_back #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_item_i  (pop_item),
    .pop_ready_o (pop_ready),
    .out_o       (out_o)
  );

  `ASSERT_NEXT(a_row_advance, clk_i, rst_ni,
    out_o.valid && out_o.ready && !out_o.last_row,
    out_o.valid && out_o.row_index == $past(out_o.row_index) + ROW_IDX_W'(1),
    "row beat did not advance to the next row")
  `ASSERT_NEXT(a_fade_steady, clk_i, rst_ni,
    out_o.valid && out_o.ready && !out_o.last_row, $stable(out_o.fade_needed),
    "fade flag changed within one frame")
  `ASSERT_NEXT(a_queue_holds, clk_i, rst_ni, in_i.valid && in_i.ready, pop_valid,
    "accepted time beat missing from the queue")
  `ASSERT_SAME(a_last_row, clk_i, rst_ni, out_o.valid && out_o.last_row,
    out_o.row_index == ROW_IDX_W'(ROWS - 1), "last-row marker on the wrong row")

endmodule

// ===== hdl/wccm_front.sv =====
// ----------------------------------------------------------------------------
// Word clock mask front end
// Accepts time beats and reduces them to slot, dots and hour word.
// ----------------------------------------------------------------------------
module wccm_front import wccm_pkg::*; (
  wccm_in_if.sink    in_i,
  output logic       push_valid_o,
  output wccm_item_t push_item_o,
  input  logic       push_ready_i
);

  logic [MINUTE_W-1:0] minute_c;
  logic [9:0]          prod;
  logic [3:0]          slot;
  logic [MINUTE_W-1:0] slot_base;
  logic [MINUTE_W-1:0] extra;
  logic [HOUR_W:0]     hour_adv;
  logic [HOUR_W:0]     hour_mod;
  logic                full;

  always_comb begin
    minute_c  = (in_i.minute > MINUTE_MAX) ? MINUTE_MAX : in_i.minute;
    prod      = 10'(minute_c) * 10'(SLOT_RECIP);
    slot      = prod[SLOT_SHIFT +: 4];
    slot_base = MINUTE_W'(slot) * MINUTE_W'(MINUTES_PER_SLOT);
    extra     = minute_c - slot_base;
    full      = (slot == 4'd0);
    hour_adv  = {1'b0, in_i.hour} + ((slot >= SLOT_HALF) ? (HOUR_W+1)'(1) : '0);
    if (hour_adv >= (HOUR_W+1)'(2 * HOURS_PER_CYCLE)) begin
      hour_mod = hour_adv - (HOUR_W+1)'(2 * HOURS_PER_CYCLE);
    end else if (hour_adv >= (HOUR_W+1)'(HOURS_PER_CYCLE)) begin
      hour_mod = hour_adv - (HOUR_W+1)'(HOURS_PER_CYCLE);
    end else begin
      hour_mod = hour_adv;
    end
  end

  always_comb begin
    push_item_o.slot      = slot;
    push_item_o.extra     = extra[2:0];
    push_item_o.full      = full;
    push_item_o.hour_word = (full && hour_mod == (HOUR_W+1)'(1)) ? HOUR_EIN : hour_mod[3:0];
  end

  assign push_valid_o = in_i.valid;
  assign in_i.ready   = push_ready_i;

endmodule

// ===== hdl/wccm_queue.sv =====
// ----------------------------------------------------------------------------
// Word clock mask queue
// Short queue of classified items between the front and back ends.
// ----------------------------------------------------------------------------
module wccm_queue import wccm_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_valid_i,
  input  wccm_item_t push_item_i,
  output logic       push_ready_o,
  output logic       pop_valid_o,
  output wccm_item_t pop_item_o,
  input  logic       pop_ready_i
);

  localparam int AW  = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  wccm_item_t       data_q [QUEUE_DEPTH];
  logic [AW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [AW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             push, pop;

  assign push_ready_o = (count_q != CNT_W'(QUEUE_DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_item_o   = data_q[rd_ptr_q];
  assign push = push_valid_i && push_ready_o;
  assign pop  = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + AW'(1) : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + AW'(1) : rd_ptr_q;
    count_d  = count_q + (push ? CNT_W'(1) : '0) - (pop ? CNT_W'(1) : '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      data_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

// ===== hdl/wccm_back.sv =====
// ----------------------------------------------------------------------------
// Word clock mask back end
// Builds an item's pixel mask, sends one row beat a cycle while out_o.ready.
// ----------------------------------------------------------------------------
module wccm_back import wccm_pkg::*; #(
  parameter int COLUMNS = 11,
  parameter int ROWS    = 10
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       pop_valid_i,
  input  wccm_item_t pop_item_i,
  output logic       pop_ready_o,
  wccm_out_if.source out_o
);

  localparam int ROW_AW = $clog2(ROWS);

  logic [COLUMNS-1:0] cur_q [ROWS];
  logic [COLUMNS-1:0] old_q [ROWS];
  logic [COLUMNS-1:0] new_mask [ROWS];
  logic [MAX_COLS-1:0] wide_row;
  logic [ROW_AW-1:0]  row_q, row_d;
  logic               busy_q, busy_d;
  logic               fade_q, fade_d;
  logic               have_q;
  logic               last, out_beat, load, differs;
  logic               fuenf, zehn, viertel, zwanzig, nach, vor, halb;
  clock_word_t        hour_w;

  assign last        = (row_q == ROW_AW'(ROWS - 1));
  assign out_beat    = out_o.valid && out_o.ready;
  assign pop_ready_o = !busy_q || (out_beat && last);
  assign load        = pop_valid_i && pop_ready_o;

  always_comb begin
    {fuenf, zehn, viertel, zwanzig, nach, vor, halb} = '0;
    unique case (pop_item_i.slot) inside
      4'd1:         {fuenf, nach} = 2'b11;
      4'd2:         {zehn, nach} = 2'b11;
      4'd3:         {viertel, nach} = 2'b11;
      4'd4:         {zwanzig, nach} = 2'b11;
      4'd5:         {fuenf, vor, halb} = 3'b111;
      4'd6:         halb = 1'b1;
      4'd7:         {fuenf, nach, halb} = 3'b111;
      4'd8:         {zwanzig, vor} = 2'b11;
      4'd9:         {viertel, vor} = 2'b11;
      4'd10:        {zehn, vor} = 2'b11;
      4'd11:        {fuenf, vor} = 2'b11;
      default:      ;
    endcase
    hour_w = (pop_item_i.hour_word == HOUR_EIN) ? W_EIN
           : HOUR_POS[pop_item_i.hour_word];
  end

  always_comb begin
    differs = 1'b0;
    for (int r = 0; r < ROWS; r++) begin
      wide_row = word_row_bits(W_ES, 4'(r)) | word_row_bits(W_IST, 4'(r))
               | word_row_bits(hour_w, 4'(r));
      if (fuenf)   wide_row |= word_row_bits(W_FUENF, 4'(r));
      if (zehn)    wide_row |= word_row_bits(W_ZEHN, 4'(r));
      if (viertel) wide_row |= word_row_bits(W_QUARTER, 4'(r));
      if (zwanzig) wide_row |= word_row_bits(W_TWENTY, 4'(r));
      if (nach)    wide_row |= word_row_bits(W_NACH, 4'(r));
      if (vor)     wide_row |= word_row_bits(W_VOR, 4'(r));
      if (halb)    wide_row |= word_row_bits(W_HALB, 4'(r));
      if (pop_item_i.full) wide_row |= word_row_bits(W_UHR, 4'(r));
      if (pop_item_i.extra >= 3'd1) wide_row |= word_row_bits(W_DOT1, 4'(r));
      if (pop_item_i.extra >= 3'd2) wide_row |= word_row_bits(W_DOT2, 4'(r));
      if (pop_item_i.extra >= 3'd3) wide_row |= word_row_bits(W_DOT3, 4'(r));
      if (pop_item_i.extra >= 3'd4) wide_row |= word_row_bits(W_DOT4, 4'(r));
      new_mask[r] = wide_row[COLUMNS-1:0];
      if (new_mask[r] != cur_q[r]) differs = 1'b1;
    end
  end

  always_comb begin
    busy_d = busy_q;
    row_d  = row_q;
    fade_d = fade_q;
    if (load) begin
      busy_d = 1'b1;
      row_d  = '0;
      fade_d = have_q && differs;
    end else if (out_beat) begin
      busy_d = !last;
      row_d  = row_q + ROW_AW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      row_q  <= '0;
      fade_q <= 1'b0;
      have_q <= 1'b0;
      for (int r = 0; r < ROWS; r++) begin
        cur_q[r] <= '0;
      end
    end else begin
      busy_q <= busy_d;
      row_q  <= row_d;
      fade_q <= fade_d;
      if (load) begin
        have_q <= 1'b1;
        cur_q  <= new_mask;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      old_q <= cur_q;
    end
  end

  assign out_o.valid        = busy_q;
  assign out_o.row_index    = ROW_IDX_W'(row_q);
  assign out_o.new_row_bits = cur_q[row_q][ROW_BITS_W-1:0];
  assign out_o.old_row_bits = old_q[row_q][ROW_BITS_W-1:0];
  assign out_o.fade_needed  = fade_q;
  assign out_o.last_row     = last;

endmodule

// ===== test/word_clock_time_to_pixel_mask_tb.sv =====
// ----------------------------------------------------------------------------
// Word clock mask testbench
// Sends time beats through the valid/ready input channel and checks every
// row beat against masks that the scoreboard builds from the same times.
// Directed times cover every five-minute slot, the full-hour words, the
// minute dots, the hour advance and wrap, and clamping of minutes above 59.
// Random times follow in phases with and without idling on either side.
// ----------------------------------------------------------------------------
module word_clock_time_to_pixel_mask_tb;
  import wccm_pkg::*;

  localparam int FRAME_ROWS    = 10;
  localparam int FRAME_COLS    = 11;
  localparam int MINUTE_LAST   = 59;
  localparam int SLOT_MINUTES  = 5;
  localparam int HOURS_ON_DIAL = 12;
  localparam int ITEMS_PER_PHASE = 65;
  localparam int TAIL_CYCLES   = 20;
  localparam int CYCLE_LIMIT   = 200000;

  typedef logic [FRAME_ROWS-1:0][FRAME_COLS-1:0] frame_t;

  typedef struct packed {
    logic [ROW_IDX_W-1:0]  row_index;
    logic [ROW_BITS_W-1:0] new_row_bits;
    logic [ROW_BITS_W-1:0] old_row_bits;
    logic                  fade_needed;
    logic                  last_row;
  } row_beat_t;

  typedef enum {
    WORD_ES, WORD_IST, WORD_FUENF, WORD_ZEHN, WORD_ZWANZIG, WORD_VIERTEL,
    WORD_VOR, WORD_NACH, WORD_HALB, WORD_UHR, WORD_EIN,
    WORD_DOT1, WORD_DOT2, WORD_DOT3, WORD_DOT4
  } word_e;

  class mask_scoreboard;
    frame_t    shown_frame;
    bit        shown_valid;
    row_beat_t expected_rows[$];
    int        errors;

    function new();
      shown_frame = '0;
      shown_valid = 1'b0;
      errors      = 0;
    endfunction

    function frame_t light(frame_t f, int col, int row, int len);
      for (int i = 0; i < len; i++) begin
        if (row < FRAME_ROWS && col + i < FRAME_COLS) f[row][col+i] = 1'b1;
      end
      return f;
    endfunction

    function frame_t light_word(frame_t f, word_e w);
      case (w)
        WORD_ES:      return light(f, 0, 0, 2);
        WORD_IST:     return light(f, 3, 0, 3);
        WORD_FUENF:   return light(f, 7, 0, 4);
        WORD_ZEHN:    return light(f, 0, 1, 4);
        WORD_ZWANZIG: return light(f, 4, 1, 7);
        WORD_VIERTEL: return light(f, 4, 2, 7);
        WORD_VOR:     return light(f, 0, 3, 3);
        WORD_NACH:    return light(f, 7, 3, 4);
        WORD_HALB:    return light(f, 0, 4, 4);
        WORD_UHR:     return light(f, 4, 9, 3);
        WORD_EIN:     return light(f, 0, 9, 3);
        WORD_DOT1:    return light(f, 7, 9, 1);
        WORD_DOT2:    return light(f, 8, 9, 1);
        WORD_DOT3:    return light(f, 9, 9, 1);
        default:      return light(f, 10, 9, 1);
      endcase
    endfunction

    function frame_t light_hour(frame_t f, int h);
      case (h)
        0:       return light(f, 5, 8, 5);
        1:       return light(f, 0, 9, 4);
        2:       return light(f, 7, 7, 4);
        3:       return light(f, 0, 5, 4);
        4:       return light(f, 7, 5, 4);
        5:       return light(f, 7, 4, 4);
        6:       return light(f, 0, 6, 5);
        7:       return light(f, 5, 6, 6);
        8:       return light(f, 1, 8, 4);
        9:       return light(f, 3, 7, 4);
        10:      return light(f, 0, 7, 4);
        default: return light(f, 5, 4, 3);
      endcase
    endfunction

    function frame_t build_frame(logic [HOUR_W-1:0] hour, logic [MINUTE_W-1:0] minute);
      frame_t f;
      int     m;
      int     slot;
      int     extra;
      int     h;
      bit     full;
      m     = (minute > MINUTE_LAST) ? MINUTE_LAST : int'(minute);
      slot  = m / SLOT_MINUTES;
      extra = m % SLOT_MINUTES;
      full  = (slot == 0);
      h     = int'(hour);
      f = '0;
      f = light_word(f, WORD_ES);
      f = light_word(f, WORD_IST);
      case (slot)
        1: begin
          f = light_word(f, WORD_FUENF);
          f = light_word(f, WORD_NACH);
        end
        2: begin
          f = light_word(f, WORD_ZEHN);
          f = light_word(f, WORD_NACH);
        end
        3: begin
          f = light_word(f, WORD_VIERTEL);
          f = light_word(f, WORD_NACH);
        end
        4: begin
          f = light_word(f, WORD_ZWANZIG);
          f = light_word(f, WORD_NACH);
        end
        5: begin
          f = light_word(f, WORD_FUENF);
          f = light_word(f, WORD_VOR);
          f = light_word(f, WORD_HALB);
        end
        6: f = light_word(f, WORD_HALB);
        7: begin
          f = light_word(f, WORD_FUENF);
          f = light_word(f, WORD_NACH);
          f = light_word(f, WORD_HALB);
        end
        8: begin
          f = light_word(f, WORD_ZWANZIG);
          f = light_word(f, WORD_VOR);
        end
        9: begin
          f = light_word(f, WORD_VIERTEL);
          f = light_word(f, WORD_VOR);
        end
        10: begin
          f = light_word(f, WORD_ZEHN);
          f = light_word(f, WORD_VOR);
        end
        11: begin
          f = light_word(f, WORD_FUENF);
          f = light_word(f, WORD_VOR);
        end
        default: ;
      endcase
      if (slot >= 5) h++;
      h = h % HOURS_ON_DIAL;
      if (h == 1 && full) f = light_word(f, WORD_EIN);
      else f = light_hour(f, h);
      if (full) f = light_word(f, WORD_UHR);
      if (extra >= 1) f = light_word(f, WORD_DOT1);
      if (extra >= 2) f = light_word(f, WORD_DOT2);
      if (extra >= 3) f = light_word(f, WORD_DOT3);
      if (extra >= 4) f = light_word(f, WORD_DOT4);
      return f;
    endfunction

    function void note_time(logic [HOUR_W-1:0] hour, logic [MINUTE_W-1:0] minute);
      frame_t    next_frame;
      bit        fade;
      row_beat_t beat;
      next_frame = build_frame(hour, minute);
      fade = shown_valid && (next_frame != shown_frame);
      for (int r = 0; r < FRAME_ROWS; r++) begin
        beat.row_index    = ROW_IDX_W'(r);
        beat.new_row_bits = ROW_BITS_W'(next_frame[r]);
        beat.old_row_bits = ROW_BITS_W'(shown_frame[r]);
        beat.fade_needed  = fade;
        beat.last_row     = (r == FRAME_ROWS - 1);
        expected_rows.push_back(beat);
      end
      shown_frame = next_frame;
      shown_valid = 1'b1;
    endfunction

    function void check_row(row_beat_t got);
      row_beat_t want;
      if (expected_rows.size() == 0) begin
        $error("row beat for row %0d arrived with no time beat pending", got.row_index);
        errors++;
        return;
      end
      want = expected_rows.pop_front();
      if (got.row_index !== want.row_index) begin
        $error("row_index: expected %0d, got %0d", want.row_index, got.row_index);
        errors++;
      end
      if (got.new_row_bits !== want.new_row_bits) begin
        $error("new_row_bits: expected %h, got %h", want.new_row_bits, got.new_row_bits);
        errors++;
      end
      if (got.old_row_bits !== want.old_row_bits) begin
        $error("old_row_bits: expected %h, got %h", want.old_row_bits, got.old_row_bits);
        errors++;
      end
      if (got.fade_needed !== want.fade_needed) begin
        $error("fade_needed: expected %b, got %b", want.fade_needed, got.fade_needed);
        errors++;
      end
      if (got.last_row !== want.last_row) begin
        $error("last_row: expected %b, got %b", want.last_row, got.last_row);
        errors++;
      end
    endfunction

    function int pending();
      return expected_rows.size();
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  wccm_in_if  in_if ();
  wccm_out_if out_if ();

  word_clock_time_to_pixel_mask u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  mask_scoreboard       sb;
  row_beat_t            got_beat;
  int                   send_idle_pct;
  int                   recv_stall_pct;
  int                   cycle_count;
  logic [HOUR_W-1:0]    last_hour;
  logic [MINUTE_W-1:0]  last_minute;

  initial clk_i = 1'b0;

  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    out_if.ready = (recv_stall_pct == 0) || ($urandom_range(0, 99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      got_beat.row_index    = out_if.row_index;
      got_beat.new_row_bits = out_if.new_row_bits;
      got_beat.old_row_bits = out_if.old_row_bits;
      got_beat.fade_needed  = out_if.fade_needed;
      got_beat.last_row     = out_if.last_row;
      sb.check_row(got_beat);
    end
  end

  task automatic send_time(input logic [HOUR_W-1:0] hour, input logic [MINUTE_W-1:0] minute);
    @(negedge clk_i);
    while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
      in_if.valid = 1'b0;
      @(negedge clk_i);
    end
    in_if.valid  = 1'b1;
    in_if.hour   = hour;
    in_if.minute = minute;
    do @(posedge clk_i); while (in_if.ready !== 1'b1);
    sb.note_time(hour, minute);
    last_hour   = hour;
    last_minute = minute;
  endtask

  task automatic send_random_time();
    int kind;
    int h;
    int m;
    kind = $urandom_range(0, 9);
    h = int'(last_hour);
    m = int'(last_minute);
    if (kind <= 5) begin
      if (m > MINUTE_LAST) m = MINUTE_LAST;
      if (h > 23) h = h % 24;
      m = m + $urandom_range(1, 7);
      if (m > MINUTE_LAST) begin
        m = m - (MINUTE_LAST + 1);
        h = (h + 1) % 24;
      end
    end else if (kind <= 8) begin
      h = $urandom_range(0, 23);
      m = $urandom_range(0, MINUTE_LAST);
    end else begin
      h = $urandom_range(0, 31);
      m = $urandom_range(0, 63);
    end
    if (kind == 6) send_time(last_hour, last_minute);
    else send_time(HOUR_W'(h), MINUTE_W'(m));
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    in_if.valid = 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  initial begin
    int idle_by_phase [4] = '{0, 54, 0, 8};
    int stall_by_phase[4] = '{0, 0, 54, 8};
    logic [HOUR_W-1:0]   dir_hour  [27] = '{
      0, 0, 1, 1, 1, 13, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11,
      23, 31, 24, 31, 12, 12, 5, 5, 5, 20, 20
    };
    logic [MINUTE_W-1:0] dir_minute[27] = '{
      0, 0, 0, 4, 5, 10, 15, 20, 25, 30, 35, 40, 45, 50, 55, 59,
      59, 59, 0, 0, 60, 63, 1, 2, 3, 33, 33
    };
    sb             = new();
    cycle_count    = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    last_hour      = '0;
    last_minute    = '0;
    rst_ni         = 1'b0;
    in_if.valid    = 1'b0;
    in_if.hour     = '0;
    in_if.minute   = '0;
    out_if.ready   = 1'b0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (dir_hour[i]) send_time(dir_hour[i], dir_minute[i]);
    wait_drained();

    for (int p = 0; p < 4; p++) begin
      send_idle_pct  = idle_by_phase[p];
      recv_stall_pct = stall_by_phase[p];
      repeat (ITEMS_PER_PHASE) send_random_time();
      wait_drained();
    end

    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
